>>> sv/fws_pkg.sv
// ----------------------------------------------------------------------------
// fws_pkg
// Types, codes and reset constants for the filter wheel step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fws_pkg;

    // request codes
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_SELECT = 2'd1;
    localparam logic [1:0] REQ_HOME   = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_ATTEMPTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITIONS     = 3'd3;
    localparam int unsigned CFG_DATA_W = 24;

    // configuration reset values
    localparam logic [15:0] RST_PULSE_TICKS   = 16'd200;
    localparam logic [23:0] RST_TIMEOUT_TICKS = 24'd20000;
    localparam logic [3:0]  RST_HOME_ATTEMPTS = 4'd8;
    localparam logic [3:0]  RST_POSITIONS     = 4'd6;

    // slot count clamp
    localparam logic [3:0] MIN_SLOTS = 4'd2;
    localparam logic [3:0] MAX_SLOTS = 4'd8;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_WAIT = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_BUSY    = 3'd1,
        ST_DONE    = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_NOHOME  = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] target_filter;
        logic       home_switch_n;
        logic       moving_sense;
    } t_in_item;

    typedef struct packed {
        logic       step_line;
        logic [2:0] current_filter;
        logic       homed;
        logic       moving;
        logic [2:0] status;
    } t_out_item;

    typedef struct packed {
        logic [15:0] pulse_ticks;
        logic [23:0] timeout_ticks;
        logic [3:0]  home_attempts;
        logic [3:0]  positions;
    } t_cfg;

endpackage

`default_nettype wire

>>> sv/fws_cfg_regs.sv
// ----------------------------------------------------------------------------
// fws_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fws_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [fws_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fws_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output fws_pkg::t_cfg                         o_cfg
);
    import fws_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_ticks   <= RST_PULSE_TICKS;
            r_cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
            r_cfg.home_attempts <= RST_HOME_ATTEMPTS;
            r_cfg.positions     <= RST_POSITIONS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PULSE_TICKS:   r_cfg.pulse_ticks   <= i_cfg_data[15:0];
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data[23:0];
                CFG_HOME_ATTEMPTS: r_cfg.home_attempts <= i_cfg_data[3:0];
                CFG_POSITIONS:     r_cfg.positions     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> sv/fws_core.sv
// ----------------------------------------------------------------------------
// fws_core
// Sequencer state and its single-item update; result formed from next state.
// ----------------------------------------------------------------------------
`default_nettype none

module fws_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  fws_pkg::t_cfg    i_cfg,
    input  fws_pkg::t_in_item i_item,
    output fws_pkg::t_out_item o_result
);
    import fws_pkg::*;

    // v mod n for v < 8, 2 <= n <= 8
    function automatic logic [2:0] f_mod_slot(input logic [2:0] v, input logic [3:0] n);
        logic [3:0] r;
        r = {1'b0, v};
        for (int k = 0; k < 4; k++) begin
            if (r >= n) r = r - n;
        end
        return r[2:0];
    endfunction

    t_phase     r_phase,  n_phase;
    logic [23:0] r_cnt,   n_cnt;
    logic [2:0] r_steps,  n_steps;
    logic [3:0] r_tries,  n_tries;
    logic       r_homing, n_homing;
    logic [2:0] r_pos,    n_pos;
    t_status    r_status, n_status;

    logic [3:0]  slots;
    logic [23:0] cnt_inc;
    logic [2:0]  tgt_m, pos_m;
    logic [3:0]  fwd_steps;
    logic [2:0]  pos_next;

    always_comb begin
        if (i_cfg.positions < MIN_SLOTS)      slots = MIN_SLOTS;
        else if (i_cfg.positions > MAX_SLOTS) slots = MAX_SLOTS;
        else                                  slots = i_cfg.positions;

        cnt_inc = r_cnt + 24'd1;
        tgt_m   = f_mod_slot(i_item.target_filter, slots);
        pos_m   = f_mod_slot(r_pos, slots);
        if (tgt_m >= pos_m) fwd_steps = {1'b0, tgt_m} - {1'b0, pos_m};
        else                fwd_steps = {1'b0, tgt_m} + slots - {1'b0, pos_m};
        pos_next = (({1'b0, pos_m} + 4'd1) == slots) ? 3'd0 : pos_m + 3'd1;

        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_steps  = r_steps;
        n_tries  = r_tries;
        n_homing = r_homing;
        n_pos    = r_pos;
        n_status = r_status;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.req_type == REQ_SELECT) begin
                    n_homing = 1'b0;
                    if (fwd_steps == 4'd0) begin
                        n_phase = PH_IDLE; n_cnt = '0; n_steps = '0; n_status = ST_DONE;
                    end else begin
                        n_steps  = fwd_steps[2:0];
                        n_phase  = PH_HIGH; n_cnt = '0; n_status = ST_BUSY;
                    end
                end else if (i_item.req_type == REQ_HOME) begin
                    n_homing = 1'b1;
                    n_tries  = i_cfg.home_attempts;
                    if (!i_item.home_switch_n) begin
                        n_pos   = '0;
                        n_phase = PH_IDLE; n_cnt = '0; n_steps = '0; n_homing = 1'b0;
                        n_status = ST_DONE;
                    end else if (i_cfg.home_attempts == 4'd0) begin
                        n_phase = PH_IDLE; n_cnt = '0; n_steps = '0; n_homing = 1'b0;
                        n_status = ST_NOHOME;
                    end else begin
                        n_tries = i_cfg.home_attempts - 4'd1;
                        n_phase = PH_HIGH; n_cnt = '0; n_status = ST_BUSY;
                    end
                end
            end
            PH_HIGH, PH_LOW: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= {8'd0, i_cfg.pulse_ticks}) begin
                    n_phase = (r_phase == PH_HIGH) ? PH_LOW : PH_WAIT;
                    n_cnt   = '0;
                end
            end
            PH_WAIT: begin
                if (!i_item.moving_sense) begin
                    n_pos = pos_next;
                    if (r_homing) begin
                        if (r_tries == 4'd0) begin
                            n_phase = PH_IDLE; n_cnt = '0; n_steps = '0; n_homing = 1'b0;
                            n_status = ST_NOHOME;
                        end else if (!i_item.home_switch_n) begin
                            n_pos   = '0;
                            n_phase = PH_IDLE; n_cnt = '0; n_steps = '0; n_homing = 1'b0;
                            n_status = ST_DONE;
                        end else begin
                            n_tries = r_tries - 4'd1;
                            n_phase = PH_HIGH; n_cnt = '0; n_status = ST_BUSY;
                        end
                    end else begin
                        n_steps = r_steps - 3'd1;
                        if (n_steps == 3'd0) begin
                            n_phase = PH_IDLE; n_cnt = '0; n_homing = 1'b0;
                            n_status = ST_DONE;
                        end else begin
                            n_phase = PH_HIGH; n_cnt = '0; n_status = ST_BUSY;
                        end
                    end
                end else begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= i_cfg.timeout_ticks) begin
                        n_phase = PH_IDLE; n_cnt = '0; n_steps = '0; n_homing = 1'b0;
                        n_status = ST_TIMEOUT;
                    end
                end
            end
        endcase

        // switch at home pins the tracked slot
        if (!i_item.home_switch_n) n_pos = '0;

        o_result.step_line      = (n_phase != PH_LOW);
        o_result.current_filter = n_pos;
        o_result.homed          = ~i_item.home_switch_n;
        o_result.moving         = i_item.moving_sense;
        o_result.status         = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cnt    <= '0;
            r_steps  <= '0;
            r_tries  <= '0;
            r_homing <= 1'b0;
            r_pos    <= '0;
            r_status <= ST_IDLE;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_steps  <= n_steps;
            r_tries  <= n_tries;
            r_homing <= n_homing;
            r_pos    <= n_pos;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

>>> sv/filter_wheel_step_sequencer.sv
// ----------------------------------------------------------------------------
// filter_wheel_step_sequencer
// Step pulse sequencer for a TTL filter wheel with slot tracking and homing.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready | i_in  (t_in_item)
//   out     | output    | o_out_valid/ i_out_ready| o_out (t_out_item)
//   cfg     | input     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// Throughput is one item per cycle while the sink does not stall; an item
// passes the input register, then the state update into the result register.
// Reset is synchronous: sequencer control state and configuration return to
// defaults, both pipeline stages empty.
// While a result waits on a stalled sink, the input stage still takes one
// more item; o_in_ready drops only when both stages hold items.
// The cfg port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module filter_wheel_step_sequencer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // item input
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  fws_pkg::t_in_item                   i_in,
    // result output
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output fws_pkg::t_out_item                  o_out,
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output      logic                           o_cfg_ready,
    input  wire logic [fws_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fws_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fws_pkg::*;

    t_cfg      cfg;
    t_out_item core_result;

    // input stage
    logic      r_s1_valid;
    t_in_item  r_s1_item;
    // result stage
    logic      r_out_valid;
    t_out_item r_out;

    logic advance;

    // the state update fires when the item moves into the result stage
    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign o_cfg_ready = 1'b1;

    fws_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fws_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cfg    (cfg),
        .i_item   (r_s1_item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_item <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // the line is only driven low mid-step
    a_low_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.step_line) |-> (o_out.status == ST_BUSY))
        else $error("step line low outside a busy sequence");

    // home switch pins the tracked slot to zero
    a_homed_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.homed) |-> (o_out.current_filter == 3'd0))
        else $error("homed result with nonzero slot");

    // a result only appears after an item sat in the input stage
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid))
        else $error("result without a staged item");

endmodule

`default_nettype wire

>>> bench/tb_filter_wheel_step_sequencer.sv
// ----------------------------------------------------------------------------
// tb_filter_wheel_step_sequencer
// Self-checking bench for the filter wheel step sequencer: predicts the
// step line, tracked slot, homing and status of every item and compares them
// with the block's results under varied settings, idling and back-pressure.
// ----------------------------------------------------------------------------

module tb_filter_wheel_step_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import fws_pkg::*;

    localparam int          CYCLE_LIMIT  = 200_000;
    localparam int          SETTLE_CYCLES = 6;      // pause after the pipeline has drained
    localparam int          LONG_HOLD    = 60;
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;    // acts as a plain tick
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // ------------------------------------------------------------------------
    // Wheel tracker: mirrors the sequencer state and keeps the results that
    // accepted items must produce, oldest first.
    // ------------------------------------------------------------------------
    class wheel_tracker;
        logic [15:0] pulse_ticks;
        logic [23:0] timeout_ticks;
        logic [3:0]  home_attempts;
        logic [3:0]  positions;

        t_phase      phase;
        logic [23:0] phase_cnt;
        logic [2:0]  steps_left;
        logic [3:0]  tries_left;
        bit          homing;
        logic [2:0]  slot;
        t_status     status;

        t_out_item   expected_reports[$];
        int          errors;

        function void reset();
            pulse_ticks   = RST_PULSE_TICKS;
            timeout_ticks = RST_TIMEOUT_TICKS;
            home_attempts = RST_HOME_ATTEMPTS;
            positions     = RST_POSITIONS;
            phase         = PH_IDLE;
            phase_cnt     = '0;
            steps_left    = '0;
            tries_left    = '0;
            homing        = 1'b0;
            slot          = '0;
            status        = ST_IDLE;
            expected_reports.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PULSE_TICKS:   pulse_ticks   = data[15:0];
                CFG_TIMEOUT_TICKS: timeout_ticks = data[23:0];
                CFG_HOME_ATTEMPTS: home_attempts = data[3:0];
                CFG_POSITIONS:     positions     = data[3:0];
                default: ;
            endcase
        endfunction

        // slot count clamped to the supported wheel sizes
        function int unsigned slot_count();
            if (positions < MIN_SLOTS) return MIN_SLOTS;
            if (positions > MAX_SLOTS) return MAX_SLOTS;
            return positions;
        endfunction

        function void start_step();
            phase     = PH_HIGH;
            phase_cnt = '0;
            status    = ST_BUSY;
        endfunction

        function void end_sequence(t_status st);
            phase      = PH_IDLE;
            phase_cnt  = '0;
            steps_left = '0;
            homing     = 1'b0;
            status     = st;
        endfunction

        function void check_home(logic home_n);
            if (!home_n) begin
                slot = '0;
                end_sequence(ST_DONE);
            end else if (tries_left == 0) begin
                end_sequence(ST_NOHOME);
            end else begin
                tries_left = tries_left - 4'd1;
                start_step();
            end
        endfunction

        function void step_complete(logic home_n);
            int unsigned n;
            n    = slot_count();
            slot = 3'((slot % n + 1) % n);
            if (homing) begin
                if (tries_left == 0) end_sequence(ST_NOHOME);
                else check_home(home_n);
            end else begin
                steps_left = steps_left - 3'd1;
                if (steps_left == 0) end_sequence(ST_DONE);
                else start_step();
            end
        endfunction

        function void take_request(t_in_item it);
            int unsigned n;
            int unsigned tgt;
            int unsigned cur;
            int unsigned fwd_steps;
            t_out_item   res;
            n = slot_count();
            case (phase)
                PH_IDLE: begin
                    if (it.req_type == REQ_SELECT) begin
                        tgt       = it.target_filter % n;
                        cur       = slot % n;
                        fwd_steps = (tgt + n - cur) % n;
                        homing    = 1'b0;
                        if (fwd_steps == 0) begin
                            end_sequence(ST_DONE);
                        end else begin
                            steps_left = 3'(fwd_steps);
                            start_step();
                        end
                    end else if (it.req_type == REQ_HOME) begin
                        homing     = 1'b1;
                        tries_left = home_attempts;
                        check_home(it.home_switch_n);
                    end
                end
                PH_HIGH: begin
                    phase_cnt = phase_cnt + 24'd1;
                    if (phase_cnt >= pulse_ticks) begin
                        phase     = PH_LOW;
                        phase_cnt = '0;
                    end
                end
                PH_LOW: begin
                    phase_cnt = phase_cnt + 24'd1;
                    if (phase_cnt >= pulse_ticks) begin
                        phase     = PH_WAIT;
                        phase_cnt = '0;
                    end
                end
                PH_WAIT: begin
                    if (!it.moving_sense) begin
                        step_complete(it.home_switch_n);
                    end else begin
                        phase_cnt = phase_cnt + 24'd1;
                        if (phase_cnt >= timeout_ticks) end_sequence(ST_TIMEOUT);
                    end
                end
                default: end_sequence(ST_IDLE);
            endcase

            // home switch low pins the tracked slot to zero
            if (!it.home_switch_n) slot = '0;

            res.step_line      = (phase != PH_LOW);
            res.current_filter = slot;
            res.homed          = ~it.home_switch_n;
            res.moving         = it.moving_sense;
            res.status         = status;
            expected_reports.push_back(res);
        endfunction

        function void compare_report(t_out_item got);
            t_out_item want;
            if (expected_reports.size() == 0) begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.step_line !== want.step_line) begin
                $error("step_line: expected %0d, got %0d", want.step_line, got.step_line);
                errors++;
            end
            if (got.current_filter !== want.current_filter) begin
                $error("current_filter: expected %0d, got %0d",
                       want.current_filter, got.current_filter);
                errors++;
            end
            if (got.homed !== want.homed) begin
                $error("homed: expected %0d, got %0d", want.homed, got.homed);
                errors++;
            end
            if (got.moving !== want.moving) begin
                $error("moving: expected %0d, got %0d", want.moving, got.moving);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals; the bench-driven ones are known from time zero
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    wheel_tracker tracker = new();
    t_in_item     directed_q[$];

    int send_idle_pct = 0;    // chance per cycle that the sender holds back
    int stall_pct     = 0;    // chance per cycle that the receiver stalls
    int hold_req      = 0;    // long receiver hold-off, picked up by the sink
    int hold_left     = 0;
    int cycle_count   = 0;

    always #1 clk = ~clk;

    filter_wheel_step_sequencer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Result sink: check accepted results, then pick next cycle's ready.
    // A pending long hold-off is counted down here.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) tracker.compare_report(out_item);
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_in_item item_of(logic [1:0] req, logic [2:0] tgt,
                                         logic home_n, logic mov);
        t_in_item it;
        it.req_type      = req;
        it.target_filter = tgt;
        it.home_switch_n = home_n;
        it.moving_sense  = mov;
        return it;
    endfunction

    // Next item: directed items first, otherwise a random one shaped by the
    // tracked state. Requests come mostly while idle so sequences run to the
    // end; some land mid-sequence as noise.
    function automatic t_in_item next_stimulus();
        t_in_item it;
        int       r;
        if (directed_q.size() != 0) return directed_q.pop_front();
        it.target_filter = 3'($urandom_range(0, 7));
        it.home_switch_n = ($urandom_range(0, 9) != 0);
        if (tracker.phase == PH_WAIT) it.moving_sense = ($urandom_range(0, 3) != 0);
        else                          it.moving_sense = 1'($urandom_range(0, 1));
        if (tracker.phase == PH_IDLE) begin
            r = $urandom_range(0, 9);
            if (r <= 3)      it.req_type = REQ_SELECT;
            else if (r <= 5) it.req_type = REQ_HOME;
            else if (r == 6) it.req_type = REQ_UNUSED;
            else             it.req_type = REQ_TICK;
        end else begin
            r = $urandom_range(0, 19);
            if (r == 0)      it.req_type = REQ_SELECT;
            else if (r == 1) it.req_type = REQ_HOME;
            else if (r == 2) it.req_type = REQ_UNUSED;
            else             it.req_type = REQ_TICK;
        end
        return it;
    endfunction

    // Offer items until count have been accepted; valid holds until taken.
    task automatic send_items(input int count);
        int sent;
        bit taken;
        sent = 0;
        while (sent < count) begin
            @(posedge clk);
            taken = in_valid && in_ready;
            if (taken) begin
                tracker.take_request(in_item);
                sent++;
            end
            if (!in_valid || taken) begin
                if (sent < count && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_item  <= next_stimulus();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    endtask

    // Sender pause: every expected result back, then let the pipe settle.
    task automatic drain();
        while (tracker.expected_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        tracker.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup_wheel(input int unsigned pulse, input int unsigned tmo,
                               input int unsigned attempts, input int unsigned slots);
        cfg_write(CFG_PULSE_TICKS,   CFG_DATA_W'(pulse));
        cfg_write(CFG_TIMEOUT_TICKS, CFG_DATA_W'(tmo));
        cfg_write(CFG_HOME_ATTEMPTS, CFG_DATA_W'(attempts));
        cfg_write(CFG_POSITIONS,     CFG_DATA_W'(slots));
    endtask

    task automatic run_phase(input int items, input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        send_items(items);
        drain();
    endtask

    initial begin
        tracker.reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset settings: requests that finish at once ---
        directed_q.push_back(item_of(REQ_TICK,   3'd0, 1'b1, 1'b0));
        directed_q.push_back(item_of(REQ_SELECT, 3'd0, 1'b1, 1'b0)); // already there
        directed_q.push_back(item_of(REQ_HOME,   3'd5, 1'b0, 1'b1)); // switch already home
        directed_q.push_back(item_of(REQ_UNUSED, 3'd7, 1'b1, 1'b1)); // unknown request
        directed_q.push_back(item_of(REQ_SELECT, 3'd6, 1'b1, 1'b0)); // 6 wraps to slot 0
        run_phase(5, 0, 0);

        // --- zero pulse, zero timeout, zero attempts, too few slots ---
        setup_wheel(0, 0, 0, 1);
        directed_q.push_back(item_of(REQ_HOME,   3'd0, 1'b1, 1'b0)); // fails with no tries
        directed_q.push_back(item_of(REQ_SELECT, 3'd1, 1'b1, 1'b1)); // one step
        directed_q.push_back(item_of(REQ_TICK,   3'd0, 1'b1, 1'b1)); // high phase over
        directed_q.push_back(item_of(REQ_TICK,   3'd0, 1'b1, 1'b1)); // low phase over
        directed_q.push_back(item_of(REQ_TICK,   3'd0, 1'b1, 1'b1)); // moving high: timeout
        directed_q.push_back(item_of(REQ_SELECT, 3'd7, 1'b1, 1'b1)); // 7 reduced mod 2
        directed_q.push_back(item_of(REQ_SELECT, 3'd0, 1'b1, 1'b1)); // ignored while busy
        directed_q.push_back(item_of(REQ_HOME,   3'd0, 1'b1, 1'b1)); // ignored while busy
        directed_q.push_back(item_of(REQ_TICK,   3'd0, 1'b1, 1'b0)); // step completes
        directed_q.push_back(item_of(REQ_TICK,   3'd0, 1'b0, 1'b0)); // home forces slot 0
        run_phase(10, 0, 0);

        // --- widest timeout, most attempts, too many slots ---
        setup_wheel(2, 24'hFF_FFFF, 15, 15);
        cfg_write(CFG_UNUSED_IDX, 24'hA5_5A5A);                     // no such register
        directed_q.push_back(item_of(REQ_HOME,   3'd3, 1'b1, 1'b1)); // not home: step
        repeat (4) directed_q.push_back(item_of(REQ_TICK, 3'd0, 1'b1, 1'b1));
        directed_q.push_back(item_of(REQ_TICK,   3'd0, 1'b0, 1'b0)); // found home
        directed_q.push_back(item_of(REQ_SELECT, 3'd7, 1'b1, 1'b0)); // seven steps
        run_phase(7, 0, 0);

        // --- random phases ---
        setup_wheel(1, 4, 3, 6);
        run_phase(150, 0, 0);

        setup_wheel(3, 10, 8, 8);
        run_phase(150, 66, 0);

        setup_wheel(2, 1, 1, 2);
        run_phase(150, 0, 66);

        // long receiver hold-off while items keep coming: input must stall
        setup_wheel(1, 6, 15, 5);
        hold_req = LONG_HOLD;
        run_phase(150, 20, 20);

        // longest pulse and timeout
        setup_wheel(16'hFFFF, 24'hFF_FFFF, 15, 8);
        run_phase(40, 0, 0);

        repeat (2) begin
            setup_wheel($urandom_range(0, 4), $urandom_range(0, 12),
                        $urandom_range(0, 15), $urandom_range(0, 15));
            run_phase(150, ($urandom_range(0, 1) != 0) ? 66 : 0,
                           ($urandom_range(0, 1) != 0) ? 66 : 20);
        end

        if (tracker.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filter_wheel_step_sequencer.f
sv/fws_pkg.sv
sv/fws_cfg_regs.sv
sv/fws_core.sv
sv/filter_wheel_step_sequencer.sv
bench/tb_filter_wheel_step_sequencer.sv
